// ===== hw/rtl/rsm_pkg.sv =====
// ----------------------------------------------------------------------------
// rsm_pkg
// Shared types, codes and helpers for the recency store with merge.
// ----------------------------------------------------------------------------
package rsm_pkg;

   localparam int HUE_PERIOD = 360;
   // ceil(2^22 / 360); gives the exact quotient for any 16-bit hue
   localparam int HUE_RECIP    = 11651;
   localparam int HUE_RECIP_SH = 22;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int TOL_W = 15;
   localparam logic [TOL_W-1:0] TOL_RESET = 15'd410;

   // opcodes
   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_FORGET = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_DONE     = 2'd0;
   localparam logic [1:0] STATUS_REPLACED = 2'd1;
   localparam logic [1:0] STATUS_DROPPED  = 2'd2;
   localparam logic [1:0] STATUS_RANGE    = 2'd3;

   // register index of the tolerance register
   localparam logic REG_TOLERANCE = 1'b0;

   typedef struct packed {
      logic [15:0] light;
      logic [15:0] correction;
      logic [8:0]  hue;
      logic [7:0]  saturation;
      logic [31:0] seconds;
      logic        bound;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_APPEND,
      ST_READ_RD,
      ST_FINISH
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       load_item;
      logic       ptr_zero;
      logic       ptr_index;
      logic       ptr_inc;
      logic       rd_en;
      logic       rd_next;
      logic       shift_wr;
      logic       append;
      logic       count_dec;
      logic       status_en;
      logic [1:0] status_val;
      logic       read_ok_set;
      logic       out_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] opcode;
      logic       index_oor;
      logic       count_zero;
      logic       count_full;
      logic       match;
      logic       last;
      logic       out_free;
   } stat_type;

   // hue mod 360 by reciprocal multiply and one back-multiply, zero for white
   function automatic logic [8:0] hue_canon(input logic [15:0] hue, input logic [7:0] sat);
      logic [29:0] prod;
      logic [7:0]  quot;
      logic [16:0] r;
      prod = {14'd0, hue} * 30'(HUE_RECIP);
      quot = prod[HUE_RECIP_SH +: 8];
      r    = {1'b0, hue} - (17'(quot) * 17'(HUE_PERIOD));
      if (sat == 8'd0) begin
         r = '0;
      end
      return r[8:0];
   endfunction

endpackage

// ===== hw/rtl/rsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// rsm_ctrl
// Sequencer for add, forget and read: search, close-up, append, respond.
// ----------------------------------------------------------------------------
module rsm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  rsm_pkg::stat_type  stat,
   output rsm_pkg::cmd_type   cmd
);

   rsm_pkg::state_type state_ff;
   rsm_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rsm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != rsm_pkg::ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rsm_pkg::ST_IDLE: begin
            if (req_valid) state_in = rsm_pkg::ST_DECODE;
         end
         rsm_pkg::ST_DECODE: begin
            case (stat.opcode)
               rsm_pkg::OP_ADD: begin
                  state_in = stat.count_zero ? rsm_pkg::ST_APPEND : rsm_pkg::ST_SRCH_RD;
               end
               rsm_pkg::OP_FORGET: begin
                  state_in = stat.index_oor ? rsm_pkg::ST_FINISH : rsm_pkg::ST_SHIFT_RD;
               end
               rsm_pkg::OP_READ: begin
                  state_in = stat.index_oor ? rsm_pkg::ST_FINISH : rsm_pkg::ST_READ_RD;
               end
               default: state_in = rsm_pkg::ST_FINISH;
            endcase
         end
         rsm_pkg::ST_SRCH_RD: state_in = rsm_pkg::ST_SRCH_CMP;
         rsm_pkg::ST_SRCH_CMP: begin
            if (stat.match) begin
               state_in = rsm_pkg::ST_SHIFT_RD;
            end else if (stat.last) begin
               state_in = stat.count_full ? rsm_pkg::ST_SHIFT_RD : rsm_pkg::ST_APPEND;
            end else begin
               state_in = rsm_pkg::ST_SRCH_RD;
            end
         end
         rsm_pkg::ST_SHIFT_RD: begin
            if (!stat.last) begin
               state_in = rsm_pkg::ST_SHIFT_WR;
            end else if (stat.opcode == rsm_pkg::OP_ADD) begin
               state_in = rsm_pkg::ST_APPEND;
            end else begin
               state_in = rsm_pkg::ST_FINISH;
            end
         end
         rsm_pkg::ST_SHIFT_WR: state_in = rsm_pkg::ST_SHIFT_RD;
         rsm_pkg::ST_APPEND:   state_in = rsm_pkg::ST_FINISH;
         rsm_pkg::ST_READ_RD:  state_in = rsm_pkg::ST_FINISH;
         rsm_pkg::ST_FINISH: begin
            if (stat.out_free) state_in = rsm_pkg::ST_IDLE;
         end
         default: state_in = rsm_pkg::ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         rsm_pkg::ST_IDLE: begin
            cmd.load_item = req_valid;
         end
         rsm_pkg::ST_DECODE: begin
            case (stat.opcode)
               rsm_pkg::OP_ADD: begin
                  cmd.ptr_zero = 1'b1;
               end
               rsm_pkg::OP_FORGET, rsm_pkg::OP_READ: begin
                  if (stat.index_oor) begin
                     cmd.status_en  = 1'b1;
                     cmd.status_val = rsm_pkg::STATUS_RANGE;
                  end else begin
                     cmd.ptr_index = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         rsm_pkg::ST_SRCH_RD: begin
            cmd.rd_en = 1'b1;
         end
         rsm_pkg::ST_SRCH_CMP: begin
            if (stat.match) begin
               cmd.status_en  = 1'b1;
               cmd.status_val = rsm_pkg::STATUS_REPLACED;
            end else if (stat.last) begin
               if (stat.count_full) begin
                  cmd.status_en  = 1'b1;
                  cmd.status_val = rsm_pkg::STATUS_DROPPED;
                  cmd.ptr_zero   = 1'b1;
               end
            end else begin
               cmd.ptr_inc = 1'b1;
            end
         end
         rsm_pkg::ST_SHIFT_RD: begin
            if (!stat.last) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_next = 1'b1;
            end else begin
               cmd.count_dec = 1'b1;
            end
         end
         rsm_pkg::ST_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            cmd.ptr_inc  = 1'b1;
         end
         rsm_pkg::ST_APPEND: begin
            cmd.append = 1'b1;
         end
         rsm_pkg::ST_READ_RD: begin
            cmd.rd_en       = 1'b1;
            cmd.read_ok_set = 1'b1;
         end
         rsm_pkg::ST_FINISH: begin
            cmd.out_load = stat.out_free;
         end
         default: ;
      endcase
   end

endmodule

// ===== hw/rtl/rsm_dpath.sv =====
// ----------------------------------------------------------------------------
// rsm_dpath
// Entry memory, count, pointer, match compare and result register.
// ----------------------------------------------------------------------------
module rsm_dpath #(
   parameter int MAX_ENTRIES = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rsm_pkg::cmd_type            cmd,
   output rsm_pkg::stat_type           stat,
   input  logic [rsm_pkg::TOL_W-1:0]   tolerance,
   input  logic [1:0]                  req_opcode,
   input  logic signed [15:0]          req_log_lux,
   input  logic signed [15:0]          req_decades,
   input  logic [15:0]                 req_hue,
   input  logic [7:0]                  req_sat,
   input  logic [31:0]                 req_seconds,
   input  logic                        req_bound,
   input  logic [7:0]                  req_index,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic [3:0]                  rsp_entry_count,
   output logic signed [15:0]          rsp_out_log_lux,
   output logic signed [15:0]          rsp_out_decades,
   output logic [8:0]                  rsp_out_hue,
   output logic [7:0]                  rsp_out_sat,
   output logic [31:0]                 rsp_out_seconds,
   output logic                        rsp_out_bound
);

   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   rsm_pkg::entry_type mem [MAX_ENTRIES];
   rsm_pkg::entry_type rd_ff;
   rsm_pkg::entry_type item_ff;
   logic [1:0]         op_ff;
   logic [7:0]         idx_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      ptr_ff, ptr_in;
   logic [1:0]         status_ff;
   logic               read_ok_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]      ptr_nx;
   logic [IW-1:0]      rd_addr;
   logic [IW-1:0]      wr_addr;
   rsm_pkg::entry_type wr_data;
   logic               wr_en;
   logic signed [16:0] diff;
   logic [16:0]        abs_diff;

   // request hold
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff              <= req_opcode;
         idx_ff             <= req_index;
         item_ff.light      <= req_log_lux;
         item_ff.correction <= req_decades;
         item_ff.hue        <= rsm_pkg::hue_canon(req_hue, req_sat);
         item_ff.saturation <= req_sat;
         item_ff.seconds    <= req_seconds;
         item_ff.bound      <= req_bound;
      end
   end

   // pointer and count
   assign ptr_nx = CW'(ptr_ff + 1'b1);

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.ptr_zero) begin
         ptr_in = '0;
      end else if (cmd.ptr_index) begin
         ptr_in = CW'(idx_ff);
      end else if (cmd.ptr_inc) begin
         ptr_in = ptr_nx;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.count_dec) begin
         count_in = CW'(count_ff - 1'b1);
      end else if (cmd.append) begin
         count_in = CW'(count_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         status_ff  <= rsm_pkg::STATUS_DONE;
         read_ok_ff <= 1'b0;
      end else begin
         if (cmd.status_en) status_ff <= cmd.status_val;
         if (cmd.read_ok_set) read_ok_ff <= 1'b1;
      end
   end

   // entry memory: one write, one registered read
   assign rd_addr = cmd.rd_next ? ptr_nx[IW-1:0] : ptr_ff[IW-1:0];
   assign wr_en   = cmd.shift_wr | cmd.append;
   assign wr_addr = cmd.append ? count_ff[IW-1:0] : ptr_ff[IW-1:0];
   assign wr_data = cmd.append ? item_ff : rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (cmd.rd_en) rd_ff <= mem[rd_addr];
   end

   // same-statement test against the entry just read
   assign diff     = {item_ff.light[15], item_ff.light} - {rd_ff.light[15], rd_ff.light};
   assign abs_diff = diff[16] ? 17'(-diff) : 17'(diff);

   always_comb begin
      stat.opcode     = op_ff;
      stat.index_oor  = ({1'b0, idx_ff} >= 9'(count_ff));
      stat.count_zero = (count_ff == '0);
      stat.count_full = (count_ff == CW'(MAX_ENTRIES));
      stat.match      = (rd_ff.saturation == item_ff.saturation) &&
                        (rd_ff.hue == item_ff.hue) &&
                        (abs_diff <= {2'b00, tolerance});
      stat.last       = ({1'b0, ptr_ff} + 1'b1) >= {1'b0, count_ff};
      stat.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // result register
   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status      <= status_ff;
         rsp_entry_count <= 4'(count_ff);
         if (read_ok_ff) begin
            rsp_out_log_lux <= rd_ff.light;
            rsp_out_decades <= rd_ff.correction;
            rsp_out_hue     <= rd_ff.hue;
            rsp_out_sat     <= rd_ff.saturation;
            rsp_out_seconds <= rd_ff.seconds;
            rsp_out_bound   <= rd_ff.bound;
         end else begin
            rsp_out_log_lux <= '0;
            rsp_out_decades <= '0;
            rsp_out_hue     <= '0;
            rsp_out_sat     <= '0;
            rsp_out_seconds <= '0;
            rsp_out_bound   <= 1'b0;
         end
      end
   end

endmodule

// ===== hw/rtl/recency_store_with_merge.sv =====
// ----------------------------------------------------------------------------
// recency_store_with_merge
// Oldest-first store of taught points with merge of repeated statements.
// ----------------------------------------------------------------------------
// Throughput: one item at a time; the next transfer is taken the cycle after the
//   result is loaded. Time is set by the entry-by-entry walk of the memory.
// Reset: synchronous, clears the entry count, the sequencer and the result
//   valid; tolerance returns to 410. Entry contents are not cleared.
// ----------------------------------------------------------------------------
module recency_store_with_merge #(
   parameter int MAX_ENTRIES = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_opcode,
   input  logic signed [15:0]                req_log_lux,
   input  logic signed [15:0]                req_decades,
   input  logic [15:0]                       req_hue,
   input  logic [7:0]                        req_sat,
   input  logic [31:0]                       req_seconds,
   input  logic                              req_bound,
   input  logic [7:0]                        req_index,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [3:0]                        rsp_entry_count,
   output logic signed [15:0]                rsp_out_log_lux,
   output logic signed [15:0]                rsp_out_decades,
   output logic [8:0]                        rsp_out_hue,
   output logic [7:0]                        rsp_out_sat,
   output logic [31:0]                       rsp_out_seconds,
   output logic                              rsp_out_bound,
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rsm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rsm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rsm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   // Register file: only the light tolerance, at byte address 0. The word
   // select is paddr[2]; byte offsets inside a word are ignored.
   logic [rsm_pkg::TOL_W-1:0] tol_ff, tol_in;
   logic                      tol_sel;
   logic                      csr_wr;

   assign csr_pready = 1'b1;
   assign tol_sel    = (csr_paddr[2] == rsm_pkg::REG_TOLERANCE);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign tol_in     = (csr_wr && tol_sel) ? csr_pwdata[rsm_pkg::TOL_W-1:0] : tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= rsm_pkg::TOL_RESET;
      end else begin
         tol_ff <= tol_in;
      end
   end

   assign csr_prdata = tol_sel ? rsm_pkg::CSR_DATA_W'(tol_ff) : '0;

   // Controller and datapath talk only through the command and status bundles.
   rsm_pkg::cmd_type  cmd;
   rsm_pkg::stat_type stat;

   rsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the entry memory, the count and the result register,
   // so a finished result can wait there while the next transfer comes in.
   rsm_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .tolerance       (tol_ff),
      .req_opcode      (req_opcode),
      .req_log_lux     (req_log_lux),
      .req_decades     (req_decades),
      .req_hue         (req_hue),
      .req_sat         (req_sat),
      .req_seconds     (req_seconds),
      .req_bound       (req_bound),
      .req_index       (req_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_out_log_lux (rsp_out_log_lux),
      .rsp_out_decades (rsp_out_decades),
      .rsp_out_hue     (rsp_out_hue),
      .rsp_out_sat     (rsp_out_sat),
      .rsp_out_seconds (rsp_out_seconds),
      .rsp_out_bound   (rsp_out_bound)
   );

endmodule

// ===== dv/recency_store_with_merge_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recency_store_with_merge_tb
// Self-checking bench for the recency store with merge. A queue-fed driver
// pushes add, forget and read requests, a shadow list predicts every response
// at the request transfer, and a monitor compares each response field by field.
// The run walks through several merge tolerances, the extremes among them.
// ----------------------------------------------------------------------------
module recency_store_with_merge_tb;

   localparam int STORE_DEPTH = 8;
   // Slowest legit spacing between two transfers is a full-store walk plus a
   // sender gap and a receiver stall; leave lots of margin.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES = 40;
   localparam int POOL_DEPTH = 12;
   localparam logic [rsm_pkg::CSR_ADDR_W-1:0] TOL_ADDR =
      rsm_pkg::CSR_ADDR_W'(4 * rsm_pkg::REG_TOLERANCE);

   // one request as the sender sees it; settle holds it back until the store
   // has answered everything already sent
   typedef struct {
      logic [1:0]         opcode;
      logic signed [15:0] log_lux;
      logic signed [15:0] decades;
      logic [15:0]        hue;
      logic [7:0]         sat;
      logic [31:0]        seconds;
      logic               bound;
      logic [7:0]         pos;
      bit                 settle;
   } store_req_type;

   typedef struct {
      logic [1:0]         status;
      logic [3:0]         entry_count;
      logic signed [15:0] log_lux;
      logic signed [15:0] decades;
      logic [8:0]         hue;
      logic [7:0]         sat;
      logic [31:0]        seconds;
      logic               bound;
   } store_rsp_type;

   // one taught point in the shadow list
   typedef struct {
      logic signed [15:0] light;
      logic signed [15:0] correction;
      logic [8:0]         hue;
      logic [7:0]         sat;
      logic [31:0]        seconds;
      logic               bound;
   } taught_pt_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_opcode = rsm_pkg::OP_ADD;
   logic signed [15:0] req_log_lux = '0;
   logic signed [15:0] req_decades = '0;
   logic [15:0]        req_hue = '0;
   logic [7:0]         req_sat = '0;
   logic [31:0]        req_seconds = '0;
   logic               req_bound = 1'b0;
   logic [7:0]         req_index = '0;

   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic [3:0]         rsp_entry_count;
   logic signed [15:0] rsp_out_log_lux;
   logic signed [15:0] rsp_out_decades;
   logic [8:0]         rsp_out_hue;
   logic [7:0]         rsp_out_sat;
   logic [31:0]        rsp_out_seconds;
   logic               rsp_out_bound;

   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [rsm_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [rsm_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [rsm_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   // bench state
   store_req_type pending_q[$];    // requests not yet offered
   store_req_type recent_adds[$];  // recent adds, reused to provoke merges
   store_rsp_type answers_q[$];    // predicted responses, oldest first
   taught_pt_type taught[$];       // shadow list, oldest first
   store_req_type req_cur;
   logic [rsm_pkg::TOL_W-1:0] merge_tol = rsm_pkg::TOL_RESET;
   bit idle_enable = 1'b1;
   int send_gap = 0;
   int hold_left = 0;
   int fail_count = 0;
   int quiet_cycles = 0;

   recency_store_with_merge #(
      .MAX_ENTRIES(STORE_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_log_lux(req_log_lux),
      .req_decades(req_decades),
      .req_hue(req_hue),
      .req_sat(req_sat),
      .req_seconds(req_seconds),
      .req_bound(req_bound),
      .req_index(req_index),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_entry_count(rsp_entry_count),
      .rsp_out_log_lux(rsp_out_log_lux),
      .rsp_out_decades(rsp_out_decades),
      .rsp_out_hue(rsp_out_hue),
      .rsp_out_sat(rsp_out_sat),
      .rsp_out_seconds(rsp_out_seconds),
      .rsp_out_bound(rsp_out_bound),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Shadow store: applies one request to the taught list and returns the
   // response the block must give for it.
   // ------------------------------------------------------------------------
   function automatic store_rsp_type apply_to_store(store_req_type q);
      store_rsp_type a;
      taught_pt_type pt;
      logic [8:0] canon;
      int light_diff;
      int hit;
      int k;
      a = '{default: '0};
      hit = -1;
      case (q.opcode)
         rsm_pkg::OP_ADD: begin
            // white points all share hue 0
            canon = (q.sat == 8'd0) ? 9'd0 : 9'(q.hue % rsm_pkg::HUE_PERIOD);
            // first entry saying the same thing gets merged away
            for (k = 0; k < taught.size(); k++) begin
               if (hit < 0 && taught[k].sat == q.sat && taught[k].hue == canon) begin
                  // 17-bit exact difference, tolerance bound is inclusive
                  light_diff = int'(q.log_lux) - int'(taught[k].light);
                  if (light_diff < 0) light_diff = -light_diff;
                  if (light_diff <= int'(merge_tol)) hit = k;
               end
            end
            if (hit >= 0) begin
               taught.delete(hit);
               a.status = rsm_pkg::STATUS_REPLACED;
            end
            // a merge always leaves room, so drop only happens without one
            if (taught.size() >= STORE_DEPTH) begin
               taught.delete(0);
               a.status = rsm_pkg::STATUS_DROPPED;
            end
            pt.light = q.log_lux;
            pt.correction = q.decades;
            pt.hue = canon;
            pt.sat = q.sat;
            pt.seconds = q.seconds;
            pt.bound = q.bound;
            taught.push_back(pt);
         end
         rsm_pkg::OP_FORGET: begin
            if (q.pos >= taught.size()) a.status = rsm_pkg::STATUS_RANGE;
            else taught.delete(q.pos);
         end
         rsm_pkg::OP_READ: begin
            if (q.pos >= taught.size()) begin
               a.status = rsm_pkg::STATUS_RANGE;
            end else begin
               a.log_lux = taught[q.pos].light;
               a.decades = taught[q.pos].correction;
               a.hue = taught[q.pos].hue;
               a.sat = taught[q.pos].sat;
               a.seconds = taught[q.pos].seconds;
               a.bound = taught[q.pos].bound;
            end
         end
         default: begin
            // unused opcode: nothing changes, read fields stay zero
         end
      endcase
      a.entry_count = 4'(taught.size());
      return a;
   endfunction

   function automatic store_req_type mk_req(logic [1:0] op, logic [15:0] lux, logic [15:0] dec,
                                            logic [15:0] hue, logic [7:0] sat,
                                            logic [31:0] secs, logic bnd, logic [7:0] pos);
      store_req_type r;
      r.opcode = op;
      r.log_lux = lux;
      r.decades = dec;
      r.hue = hue;
      r.sat = sat;
      r.seconds = secs;
      r.bound = bnd;
      r.pos = pos;
      r.settle = 1'b0;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Random request. About half are adds, and a good share of those repeat
   // an earlier point with the light nudged around the tolerance edge, so
   // merges, near misses and drops from a full list all come up often.
   // ------------------------------------------------------------------------
   function automatic store_req_type random_req();
      store_req_type r;
      store_req_type p;
      int roll;
      int span;
      int lux;
      roll = $urandom_range(0, 99);
      r.log_lux = 16'($urandom);
      r.decades = 16'($urandom);
      r.hue = 16'($urandom);
      r.seconds = $urandom;
      r.bound = 1'($urandom);
      case ($urandom_range(0, 3))
         0: r.sat = 8'd0;
         1: r.sat = 8'hff;
         2: r.sat = 8'($urandom_range(1, 3));
         default: r.sat = 8'($urandom);
      endcase
      r.pos = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 9)) :
                                             8'($urandom_range(0, 255));
      r.settle = ($urandom_range(0, 99) == 0);
      if (roll < 55) begin
         r.opcode = rsm_pkg::OP_ADD;
         if (recent_adds.size() > 0 && $urandom_range(0, 99) < 45) begin
            p = recent_adds[$urandom_range(0, recent_adds.size() - 1)];
            r.sat = p.sat;
            // same canonical hue, raw value wrapped a random number of turns
            if (p.sat != 8'd0) begin
               r.hue = 16'(p.hue % rsm_pkg::HUE_PERIOD +
                           rsm_pkg::HUE_PERIOD * $urandom_range(0, 181));
            end
            span = $urandom_range(0, 2 * int'(merge_tol) + 4);
            lux = int'(p.log_lux) + span - int'(merge_tol) - 2;
            if (lux > 32767) lux = 32767;
            if (lux < -32768) lux = -32768;
            r.log_lux = 16'(lux);
         end
         recent_adds.push_back(r);
         if (recent_adds.size() > POOL_DEPTH) recent_adds.delete(0);
      end else if (roll < 75) begin
         r.opcode = rsm_pkg::OP_FORGET;
      end else begin
         r.opcode = rsm_pkg::OP_READ;
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Driver: offers the next pending request after its random gap. The
   // prediction is made at the request transfer, so the shadow list always
   // sees requests in the order the block takes them.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      logic offer;
      offer = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            answers_q.push_back(apply_to_store(req_cur));
         end
         // channel free after this edge: either idle or just transferred
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_q.size() > 0 &&
                         !(pending_q[0].settle && answers_q.size() > 0)) begin
               req_cur = pending_q.pop_front();
               req_opcode <= req_cur.opcode;
               req_log_lux <= req_cur.log_lux;
               req_decades <= req_cur.decades;
               req_hue <= req_cur.hue;
               req_sat <= req_cur.sat;
               req_seconds <= req_cur.seconds;
               req_bound <= req_cur.bound;
               req_index <= req_cur.pos;
               offer = 1'b1;
               send_gap = idle_enable ? $urandom_range(0, 9) : 0;
            end
            req_valid <= offer;
         end
      end
   end

   function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
         fail_count++;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Monitor: checks each response transfer against the oldest prediction and
   // draws a stall for the next response. The stall counts down only while a
   // response is waiting, so every response sits its full stall.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      store_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answers_q.size() == 0) begin
               $error("response transfer with no request outstanding");
               fail_count++;
            end else begin
               want = answers_q.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("entry_count", 32'(want.entry_count), 32'(rsp_entry_count));
               check_field("out_log_lux", 32'(want.log_lux), 32'(rsp_out_log_lux));
               check_field("out_decades", 32'(want.decades), 32'(rsp_out_decades));
               check_field("out_hue", 32'(want.hue), 32'(rsp_out_hue));
               check_field("out_sat", 32'(want.sat), 32'(rsp_out_sat));
               check_field("out_seconds", want.seconds, rsp_out_seconds);
               check_field("out_bound", 32'(want.bound), 32'(rsp_out_bound));
            end
            hold_left = idle_enable ? $urandom_range(0, 9) : 0;
         end else if (rsp_valid && hold_left > 0) begin
            hold_left--;
         end
         rsp_stall <= (hold_left > 0);
      end
   end

   // watchdog: any transfer or register access counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // sampled on the falling edge so the driver's edge updates have settled
   task automatic wait_store_idle();
      while (pending_q.size() > 0 || req_valid || answers_q.size() > 0 || rsp_valid) begin
         @(negedge clock);
      end
   endtask

   // write the tolerance, then read it back in a second access
   task automatic write_merge_tol(input logic [rsm_pkg::TOL_W-1:0] value);
      logic [rsm_pkg::CSR_DATA_W-1:0] back;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= TOL_ADDR;
      csr_pwdata <= rsm_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      merge_tol = value;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      back = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (back !== rsm_pkg::CSR_DATA_W'(value)) begin
         $error("same_light_tolerance: expected 0x%0h, got 0x%0h", value, back);
         fail_count++;
      end
   endtask

   // one phase: drain, retune, then queue a batch of random requests
   task automatic run_phase(int n_items, logic [rsm_pkg::TOL_W-1:0] tol, bit idle_on);
      wait_store_idle();
      write_merge_tol(tol);
      @(negedge clock);
      idle_enable = idle_on;
      repeat (n_items) pending_q.push_back(random_req());
   endtask

   initial begin
      store_req_type r;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // --- directed part, default tolerance of 410 ---
      // empty store: both index ops are out of range
      pending_q.push_back(mk_req(rsm_pkg::OP_READ, 16'h0, 16'h0, 16'h0, 8'h0, 32'h0,
                                 1'b0, 8'd0));
      pending_q.push_back(mk_req(rsm_pkg::OP_FORGET, 16'h0, 16'h0, 16'h0, 8'h0, 32'h0,
                                 1'b0, 8'd255));
      // field extremes; white point with the largest raw hue canonicalizes to 0
      pending_q.push_back(mk_req(rsm_pkg::OP_ADD, 16'h8000, 16'h7fff, 16'hffff, 8'h00,
                                 32'hffffffff, 1'b1, 8'd0));
      pending_q.push_back(mk_req(rsm_pkg::OP_ADD, 16'h7fff, 16'h8000, 16'd359, 8'hff,
                                 32'h0, 1'b0, 8'd255));
      // hue of a full turn folds to 0
      pending_q.push_back(mk_req(rsm_pkg::OP_ADD, 16'h0000, 16'h0000, 16'd360, 8'h01,
                                 32'h1, 1'b0, 8'd0));
      // 65535 mod 360 = 15
      pending_q.push_back(mk_req(rsm_pkg::OP_ADD, 16'd100, 16'h1234, 16'hffff, 8'hff,
                                 32'h55, 1'b0, 8'd0));
      // light exactly at the tolerance: merges
      pending_q.push_back(mk_req(rsm_pkg::OP_ADD, 16'd510, 16'h4321, 16'd15, 8'hff,
                                 32'h56, 1'b1, 8'd0));
      // one past the tolerance: kept as a separate point
      pending_q.push_back(mk_req(rsm_pkg::OP_ADD, 16'd921, 16'h1111, 16'd15, 8'hff,
                                 32'h57, 1'b0, 8'd0));
      // full-scale light difference against the first point: no merge
      pending_q.push_back(mk_req(rsm_pkg::OP_ADD, 16'h7fff, 16'h2222, 16'd0, 8'h00,
                                 32'h58, 1'b0, 8'd0));
      // white point at the tolerance edge of the first one, raw hue irrelevant
      pending_q.push_back(mk_req(rsm_pkg::OP_ADD, 16'h819a, 16'h3333, 16'd720, 8'h00,
                                 32'h59, 1'b1, 8'd0));
      // fill the list, then overflow it
      pending_q.push_back(mk_req(rsm_pkg::OP_ADD, 16'd2000, 16'h0101, 16'd90, 8'd10,
                                 32'h60, 1'b0, 8'd0));
      pending_q.push_back(mk_req(rsm_pkg::OP_ADD, 16'd3000, 16'h0202, 16'd180, 8'd11,
                                 32'h61, 1'b1, 8'd0));
      pending_q.push_back(mk_req(rsm_pkg::OP_ADD, 16'd4000, 16'h0303, 16'd270, 8'd12,
                                 32'h62, 1'b0, 8'd0));
      // merge into a full list: replaced, nothing dropped
      pending_q.push_back(mk_req(rsm_pkg::OP_ADD, 16'hfe66, 16'h0404, 16'd0, 8'h01,
                                 32'h63, 1'b1, 8'd0));
      // reads at both ends and past them
      pending_q.push_back(mk_req(rsm_pkg::OP_READ, 16'h0, 16'h0, 16'h0, 8'h0, 32'h0,
                                 1'b0, 8'd0));
      pending_q.push_back(mk_req(rsm_pkg::OP_READ, 16'h0, 16'h0, 16'h0, 8'h0, 32'h0,
                                 1'b0, 8'd7));
      pending_q.push_back(mk_req(rsm_pkg::OP_READ, 16'h0, 16'h0, 16'h0, 8'h0, 32'h0,
                                 1'b0, 8'd8));
      pending_q.push_back(mk_req(rsm_pkg::OP_READ, 16'h0, 16'h0, 16'h0, 8'h0, 32'h0,
                                 1'b0, 8'd255));
      // forget the newest, the oldest, then out of range
      pending_q.push_back(mk_req(rsm_pkg::OP_FORGET, 16'h0, 16'h0, 16'h0, 8'h0, 32'h0,
                                 1'b0, 8'd7));
      pending_q.push_back(mk_req(rsm_pkg::OP_FORGET, 16'h0, 16'h0, 16'h0, 8'h0, 32'h0,
                                 1'b0, 8'd0));
      pending_q.push_back(mk_req(rsm_pkg::OP_FORGET, 16'h0, 16'h0, 16'h0, 8'h0, 32'h0,
                                 1'b0, 8'd200));
      // sender holds this one until the store has answered everything
      r = mk_req(rsm_pkg::OP_READ, 16'h0, 16'h0, 16'h0, 8'h0, 32'h0, 1'b0, 8'd3);
      r.settle = 1'b1;
      pending_q.push_back(r);

      // --- random part across tolerance settings ---
      run_phase(200, '0, 1'b1);                                   // exact light match only
      run_phase(150, {rsm_pkg::TOL_W{1'b1}}, 1'b1);               // widest tolerance
      run_phase(250, rsm_pkg::TOL_W'($urandom_range(1, 2000)), 1'b1);
      run_phase(150, rsm_pkg::TOL_RESET, 1'b0);                   // default, no idling
      run_phase(200, rsm_pkg::TOL_W'(1), 1'b1);

      wait_store_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (answers_q.size() != 0) begin
         $error("%0d responses never arrived", answers_q.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/rsm_pkg.sv
hw/rtl/rsm_ctrl.sv
hw/rtl/rsm_dpath.sv
hw/rtl/recency_store_with_merge.sv
dv/recency_store_with_merge_tb.sv
